>>> src/tfm_pkg.sv
package tfm_pkg;

    localparam int unsigned LevelW = 8;
    localparam int unsigned DurW   = 4;
    localparam int unsigned FrameW = 11;
    localparam int unsigned CntW   = 4;
    localparam int unsigned CfgAddrW = 2;

    localparam logic [DurW-1:0] DUR_SHORT     = 4'd5;
    localparam logic [DurW-1:0] DUR_LONG      = 4'd10;
    localparam logic [DurW-1:0] DUR_LONG_FAST = 4'd9;

    localparam logic [LevelW-1:0] RESET_HIGH = 8'hE0;
    localparam logic [LevelW-1:0] RESET_LOW  = 8'h20;

    localparam logic [CfgAddrW-1:0] CFG_FAST_MODE  = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_HIGH_LEVEL = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_LOW_LEVEL  = 2'd2;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_BIT  = 1'b1;

    // stop bits 1, 1, 0 sit above the data byte, sent lsb first
    localparam logic [2:0] STOP_BITS = 3'b011;

    typedef logic [2:0] uaddr_t;

    // microcode entry points
    localparam uaddr_t U_ONE  = 3'd0;
    localparam uaddr_t U_ZERO = 3'd4;

    typedef struct packed {
        logic hi;        // high level half-cycle
        logic long_half; // long duration
        logic bit_end;   // last half of this bit: take next bit or finish
    } uword_t;

    // segment request from sequencer to output stage
    typedef struct packed {
        logic valid;
        logic hi;
        logic long_half;
        logic last;
    } seg_t;

    function automatic uword_t urom(input uaddr_t addr);
        uword_t w;
        case (addr)
            3'd0:    w = '{hi: 1'b0, long_half: 1'b0, bit_end: 1'b0};
            3'd1:    w = '{hi: 1'b1, long_half: 1'b0, bit_end: 1'b0};
            3'd2:    w = '{hi: 1'b0, long_half: 1'b0, bit_end: 1'b0};
            3'd3:    w = '{hi: 1'b1, long_half: 1'b0, bit_end: 1'b1};
            3'd4:    w = '{hi: 1'b0, long_half: 1'b1, bit_end: 1'b0};
            3'd5:    w = '{hi: 1'b1, long_half: 1'b1, bit_end: 1'b1};
            default: w = '{hi: 1'b0, long_half: 1'b0, bit_end: 1'b1};
        endcase
        return w;
    endfunction

endpackage

>>> src/tfm_sequencer.sv
module tfm_sequencer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     action,
    input  logic [tfm_pkg::LevelW-1:0] data,
    input  logic                     advance,
    output logic                     busy,
    output tfm_pkg::seg_t            seg
);
    import tfm_pkg::*;

    logic              busy_reg, busy_next;
    uaddr_t            step_reg, step_next;
    logic [FrameW-1:0] bits_reg, bits_next;
    logic [CntW-1:0]   left_reg, left_next;
    uword_t            uw;
    logic              final_bit;

    assign uw        = urom(step_reg);
    assign final_bit = (left_reg == CntW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= U_ONE;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        bits_next = bits_reg;
        left_next = left_reg;
        if (start)
        begin
            busy_next = 1'b1;
            if (action == ACT_BIT)
            begin
                bits_next = {{(FrameW-1){1'b0}}, data[0]};
                left_next = CntW'(1);
                step_next = data[0] ? U_ONE : U_ZERO;
            end
            else
            begin
                bits_next = {STOP_BITS, data};
                left_next = CntW'(FrameW);
                step_next = data[0] ? U_ONE : U_ZERO;
            end
        end
        else if (busy_reg && advance)
        begin
            if (uw.bit_end)
            begin
                // dispatch on the next bit while the current one closes
                bits_next = bits_reg >> 1;
                left_next = left_reg - CntW'(1);
                step_next = bits_reg[1] ? U_ONE : U_ZERO;
                if (final_bit)
                    busy_next = 1'b0;
            end
            else
            begin
                step_next = step_reg + uaddr_t'(1);
            end
        end
    end

    assign busy          = busy_reg;
    assign seg.valid     = busy_reg;
    assign seg.hi        = uw.hi;
    assign seg.long_half = uw.long_half;
    assign seg.last      = uw.bit_end && final_bit;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("start while sequencer busy");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && advance && seg.last) |=> !busy_reg)
        else $error("sequencer still busy after final segment");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != '0))
        else $error("busy with no bits left");

endmodule

>>> src/tape_fsk_byte_modulator.sv
// Channel  Dir  Fields (lsb up)                          Handshake
// s_axis   in   tdata: data[7:0]; tuser: action          tvalid/tready
// m_axis   out  tdata: level[7:0], duration[11:8]; tlast tvalid/tready
// cfg      in   0 fast_mode, 1 high_level, 2 low_level   cfg_wr_en, no wait
//
// One half-cycle segment per cycle unless m_tready stalls, from a 6-word microcode
// loop: a framed byte gives 26 to 42 segments, a single bit 2 or 4.
// A new word is taken the cycle after the last segment enters the output register.
// With the output full, m_tready low holds the sequencer; s_tready drops while busy.
// Reset is asynchronous: idle sequencer, empty output, register reset values.
module tape_fsk_byte_modulator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data[7:0]
    input  logic                         s_tuser,   // action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // level[7:0], duration[11:8], zero
    output logic                         m_tlast,
    input  logic                         cfg_wr_en,
    input  logic [tfm_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [7:0]                   cfg_wdata
);
    import tfm_pkg::*;

    logic              fast_reg;
    logic [LevelW-1:0] high_reg, low_reg;

    logic              ovalid_reg, ovalid_next;
    logic [LevelW-1:0] olevel_reg, olevel_next;
    logic [DurW-1:0]   odur_reg, odur_next;
    logic              olast_reg, olast_next;

    logic  busy, start, advance;
    seg_t  seg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg <= 1'b0;
            high_reg <= RESET_HIGH;
            low_reg  <= RESET_LOW;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_FAST_MODE:  fast_reg <= cfg_wdata[0];
                CFG_HIGH_LEVEL: high_reg <= cfg_wdata;
                CFG_LOW_LEVEL:  low_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && !busy;
    assign advance  = !ovalid_reg || m_tready;

    tfm_sequencer u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .action  (s_tuser),
        .data    (s_tdata),
        .advance (advance),
        .busy    (busy),
        .seg     (seg)
    );

    always_comb
    begin
        ovalid_next = ovalid_reg;
        olevel_next = olevel_reg;
        odur_next   = odur_reg;
        olast_next  = olast_reg;
        if (advance)
        begin
            ovalid_next = seg.valid;
            olevel_next = seg.hi ? high_reg : low_reg;
            if (!seg.long_half)
                odur_next = DUR_SHORT;
            else if (fast_reg)
                odur_next = DUR_LONG_FAST;
            else
                odur_next = DUR_LONG;
            olast_next  = seg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        olevel_reg <= olevel_next;
        odur_reg   <= odur_next;
        olast_reg  <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {{(16-LevelW-DurW){1'b0}}, odur_reg, olevel_reg};
    assign m_tlast  = olast_reg;

    a_dur_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (odur_reg == DUR_SHORT || odur_reg == DUR_LONG
                      || odur_reg == DUR_LONG_FAST))
        else $error("illegal segment duration");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> busy)
        else $error("accepted word did not start the sequencer");

    a_seg_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && advance) |=> m_tvalid)
        else $error("segment lost on the way to the output register");

endmodule

>>> verif/tape_fsk_byte_modulator_tb.sv
`timescale 1ns / 100ps

module tape_fsk_byte_modulator_tb;
    import tfm_pkg::*;

    localparam logic [1:0] CFG_NONE      = 2'd3;  // no register behind this index
    localparam logic [3:0] RUN_SHORT     = 4'd5;
    localparam logic [3:0] RUN_LONG      = 4'd10;
    localparam logic [3:0] RUN_LONG_FAST = 4'd9;
    localparam int         HOLD_CYCLES   = 250;

    typedef struct packed {
        logic [7:0] level;
        logic [3:0] duration;
        logic       last;
    } segment_t;

    class segment_scoreboard;
        logic       fast;
        logic [7:0] high_lvl;
        logic [7:0] low_lvl;
        segment_t   segq[$];
        int         errors;

        function new();
            fast     = 1'b0;
            high_lvl = 8'hE0;
            low_lvl  = 8'h20;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] val);
            case (idx)
                CFG_FAST_MODE:  fast     = val[0];
                CFG_HIGH_LEVEL: high_lvl = val;
                CFG_LOW_LEVEL:  low_lvl  = val;
                default:        ;
            endcase
        endfunction

        // low first, then alternate; a one is four short halves, a zero two long
        function void push_bit(logic b);
            segment_t s;
            int       halves;
            halves = b ? 4 : 2;
            for (int h = 0; h < halves; h++) begin
                s.level    = h[0] ? high_lvl : low_lvl;
                s.duration = b ? RUN_SHORT : (fast ? RUN_LONG_FAST : RUN_LONG);
                s.last     = 1'b0;
                segq.push_back(s);
            end
        endfunction

        function void note_word(logic act, logic [7:0] d);
            logic [10:0] frame;
            frame = {1'b0, 1'b1, 1'b1, d};  // stop bits 1, 1, 0 after the data, lsb first
            if (act == ACT_BIT)
                push_bit(d[0]);
            else
                for (int i = 0; i < 11; i++)
                    push_bit(frame[i]);
            segq[segq.size()-1].last = 1'b1;
        endfunction

        function void check_seg(logic [15:0] td, logic tl);
            segment_t exp_seg;
            if (segq.size() == 0) begin
                $display("%0t: unexpected word tdata=%h tlast=%b", $time, td, tl);
                errors++;
                return;
            end
            exp_seg = segq.pop_front();
            if (td[7:0] !== exp_seg.level) begin
                $display("%0t: level mismatch exp=%0d act=%0d", $time, exp_seg.level, td[7:0]);
                errors++;
            end
            if (td[11:8] !== exp_seg.duration) begin
                $display("%0t: duration mismatch exp=%0d act=%0d",
                         $time, exp_seg.duration, td[11:8]);
                errors++;
            end
            if (td[15:12] !== 4'd0) begin
                $display("%0t: padding mismatch exp=0 act=%h", $time, td[15:12]);
                errors++;
            end
            if (tl !== exp_seg.last) begin
                $display("%0t: last mismatch exp=%b act=%b", $time, exp_seg.last, tl);
                errors++;
            end
        endfunction

        function int pending();
            return segq.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    segment_scoreboard sb;
    bit gaps_on;
    bit stall_on;
    bit want_hold;

    tape_fsk_byte_modulator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // both handshakes sampled with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_seg(m_tdata, m_tlast);
        end
    end

    // receiver: random stalls, and one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (want_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                want_hold = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // leaves s_tvalid high unless a gap follows
    task automatic send_word(input logic act, input logic [7:0] d);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
        end
        @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] fast_w, input logic [7:0] hi,
                               input logic [7:0] lo);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FAST_MODE;
        cfg_wdata <= fast_w;
        @(posedge clk);
        sb.write_reg(CFG_FAST_MODE, fast_w);
        cfg_addr  <= CFG_HIGH_LEVEL;
        cfg_wdata <= hi;
        @(posedge clk);
        sb.write_reg(CFG_HIGH_LEVEL, hi);
        cfg_addr  <= CFG_LOW_LEVEL;
        cfg_wdata <= lo;
        @(posedge clk);
        sb.write_reg(CFG_LOW_LEVEL, lo);
        cfg_addr  <= CFG_NONE;
        cfg_wdata <= 8'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_config();
        logic [7:0] hi;
        logic [7:0] lo;
        hi = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        lo = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
        // upper bits of the fast_mode write must be ignored
        load_config(8'($urandom), hi, lo);
    endtask

    task automatic random_phase(input int n);
        logic act;
        for (int i = 0; i < n; i++)
        begin
            act = ($urandom_range(0, 2) == 0) ? ACT_BIT : ACT_BYTE;
            send_word(act, 8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        sb        = new();
        gaps_on   = 1'b0;
        stall_on  = 1'b0;
        want_hold = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tuser   <= ACT_BYTE;
        cfg_wr_en <= 1'b0;
        cfg_addr  <= CFG_FAST_MODE;
        cfg_wdata <= 8'h00;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset levels, slow mode
        send_word(ACT_BIT, 8'h00);
        send_word(ACT_BIT, 8'h01);
        send_word(ACT_BIT, 8'hFE);
        send_word(ACT_BIT, 8'hFF);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'hA5);
        send_word(ACT_BYTE, 8'h5A);
        send_word(ACT_BYTE, 8'h01);
        send_word(ACT_BYTE, 8'h80);
        drain();

        load_config(8'hFF, 8'hFF, 8'h00);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BIT, 8'h00);
        send_word(ACT_BIT, 8'h01);
        send_word(ACT_BYTE, 8'h3C);
        drain();

        load_config(8'hFE, 8'h00, 8'hFF);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BIT, 8'h55);
        send_word(ACT_BIT, 8'hAA);
        send_word(ACT_BYTE, 8'hC3);
        drain();

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        random_config();
        random_phase(30);

        // long receiver hold while words keep coming
        random_config();
        want_hold = 1'b1;
        random_phase(30);

        random_config();
        random_phase(30);

        load_config(8'h01, 8'hFF, 8'h00);
        random_phase(25);

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        random_config();
        random_phase(35);

        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/tfm_pkg.sv
src/tfm_sequencer.sv
src/tape_fsk_byte_modulator.sv
verif/tape_fsk_byte_modulator_tb.sv
